### design/box_overlap_volume_ratio_core_assert.svh
// assertion helpers for the box overlap ratio core
`ifndef BOX_OVERLAP_VOLUME_RATIO_CORE_ASSERT_SVH
`define BOX_OVERLAP_VOLUME_RATIO_CORE_ASSERT_SVH

// same-cycle implication
`define BOXOV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box overlap check failed");

// next-cycle implication
`define BOXOV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box overlap check failed");

`endif

### design/boxov_pkg.sv
package boxov_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int NUM_FIELDS      = 12;

    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int MAG_W      = COORD_WIDTH;
    localparam int PAIR_W     = 2 * MAG_W;
    localparam int VOL_W      = 3 * MAG_W;
    localparam int RATIO_W    = RATIO_FRAC_BITS + 1;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = ((NUM_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RATIO_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISJOINT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                zero;
    } ctl_t;

endpackage

### design/boxov_front.sv
module boxov_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [boxov_pkg::IN_DATA_W-1:0]  in_data,
    output boxov_pkg::ctl_t                  ctl,
    output logic [2:0][boxov_pkg::MAG_W-1:0] ext,
    output logic [2:0][boxov_pkg::MAG_W-1:0] ov
);

    localparam int CW = boxov_pkg::COORD_WIDTH;
    localparam int DW = boxov_pkg::DIFF_W;
    localparam int MW = boxov_pkg::MAG_W;

    boxov_pkg::coord_t smax [3];
    boxov_pkg::coord_t smin [3];
    boxov_pkg::coord_t mmax [3];
    boxov_pkg::coord_t mmin [3];
    boxov_pkg::coord_t hi   [3];
    boxov_pkg::coord_t lo   [3];
    logic signed [DW-1:0] e_d [3];
    logic signed [DW-1:0] o_d [3];

    logic disjoint;
    logic zero_ext;
    logic neg_par;
    logic zero_ov;

    boxov_pkg::ctl_t                  ctl_next;
    boxov_pkg::ctl_t                  ctl_reg;
    logic [2:0][boxov_pkg::MAG_W-1:0] ext_next;
    logic [2:0][boxov_pkg::MAG_W-1:0] ext_reg;
    logic [2:0][boxov_pkg::MAG_W-1:0] ov_next;
    logic [2:0][boxov_pkg::MAG_W-1:0] ov_reg;

    always_comb
    begin
        disjoint = 1'b0;
        zero_ext = 1'b0;
        neg_par  = 1'b0;
        zero_ov  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            smax[a] = in_data[a * CW +: CW];
            smin[a] = in_data[(3 + a) * CW +: CW];
            mmax[a] = in_data[(6 + a) * CW +: CW];
            mmin[a] = in_data[(9 + a) * CW +: CW];
            hi[a]   = (smax[a] < mmax[a]) ? smax[a] : mmax[a];
            lo[a]   = (smin[a] > mmin[a]) ? smin[a] : mmin[a];
            e_d[a]  = $signed({smax[a][CW-1], smax[a]}) - $signed({smin[a][CW-1], smin[a]});
            o_d[a]  = $signed({hi[a][CW-1], hi[a]}) - $signed({lo[a][CW-1], lo[a]});
            if ((smax[a] < mmin[a]) || (smin[a] > mmax[a]))
            begin
                disjoint = 1'b1;
            end
            if (e_d[a] == '0)
            begin
                zero_ext = 1'b1;
            end
            neg_par = neg_par ^ e_d[a][DW-1];
            ext_next[a] = e_d[a][DW-1] ? MW'(-e_d[a]) : e_d[a][MW-1:0];
            if (o_d[a][DW-1] || (o_d[a] == '0))
            begin
                zero_ov    = 1'b1;
                ov_next[a] = '0;
            end
            else
            begin
                ov_next[a] = o_d[a][boxov_pkg::MAG_W-1:0];
            end
        end
        ctl_next.valid = in_valid;
        ctl_next.zero  = zero_ov;
        priority if (disjoint)
        begin
            ctl_next.status = boxov_pkg::ST_DISJOINT;
        end
        else if (zero_ext || neg_par)
        begin
            ctl_next.status = boxov_pkg::ST_EMPTY;
        end
        else
        begin
            ctl_next.status = boxov_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ext_reg <= ext_next;
            ov_reg  <= ov_next;
        end
    end

    assign ctl = ctl_reg;
    assign ext = ext_reg;
    assign ov  = ov_reg;

endmodule

### design/boxov_mult.sv
module boxov_mult (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  boxov_pkg::ctl_t                  ctl_in,
    input  logic [2:0][boxov_pkg::MAG_W-1:0] ext,
    input  logic [2:0][boxov_pkg::MAG_W-1:0] ov,
    output boxov_pkg::ctl_t                  ctl_out,
    output logic [boxov_pkg::VOL_W-1:0]      den,
    output logic [boxov_pkg::VOL_W-1:0]      num
);

    localparam int MW = boxov_pkg::MAG_W;
    localparam int PW = boxov_pkg::PAIR_W;
    localparam int VW = boxov_pkg::VOL_W;

    // xy products
    boxov_pkg::ctl_t ctl_a_reg;
    logic [PW-1:0]   den_pair_next;
    logic [PW-1:0]   den_pair_reg;
    logic [PW-1:0]   num_pair_next;
    logic [PW-1:0]   num_pair_reg;
    logic [MW-1:0]   ext_z_reg;
    logic [MW-1:0]   ov_z_reg;

    // z partial products
    boxov_pkg::ctl_t ctl_b_reg;
    logic [PW-1:0]   den_lo_next;
    logic [PW-1:0]   den_lo_reg;
    logic [PW-1:0]   den_hi_next;
    logic [PW-1:0]   den_hi_reg;
    logic [PW-1:0]   num_lo_next;
    logic [PW-1:0]   num_lo_reg;
    logic [PW-1:0]   num_hi_next;
    logic [PW-1:0]   num_hi_reg;

    // full volumes
    boxov_pkg::ctl_t ctl_c_reg;
    logic [VW-1:0]   den_next;
    logic [VW-1:0]   den_reg;
    logic [VW-1:0]   num_next;
    logic [VW-1:0]   num_reg;

    always_comb
    begin
        den_pair_next = ext[0] * ext[1];
        num_pair_next = ov[0] * ov[1];
        den_lo_next   = den_pair_reg[MW-1:0] * ext_z_reg;
        den_hi_next   = den_pair_reg[PW-1:MW] * ext_z_reg;
        num_lo_next   = num_pair_reg[MW-1:0] * ov_z_reg;
        num_hi_next   = num_pair_reg[PW-1:MW] * ov_z_reg;
        den_next      = (VW'(den_hi_reg) << MW) + VW'(den_lo_reg);
        num_next      = (VW'(num_hi_reg) << MW) + VW'(num_lo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_pair_reg <= den_pair_next;
            num_pair_reg <= num_pair_next;
            ext_z_reg    <= ext[2];
            ov_z_reg     <= ov[2];
            den_lo_reg   <= den_lo_next;
            den_hi_reg   <= den_hi_next;
            num_lo_reg   <= num_lo_next;
            num_hi_reg   <= num_hi_next;
            den_reg      <= den_next;
            num_reg      <= num_next;
        end
    end

    assign ctl_out = ctl_c_reg;
    assign den     = den_reg;
    assign num     = num_reg;

endmodule

### design/boxov_div.sv
module boxov_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  boxov_pkg::ctl_t               ctl_in,
    input  logic [boxov_pkg::VOL_W-1:0]   num,
    input  logic [boxov_pkg::VOL_W-1:0]   den,
    output boxov_pkg::ctl_t               ctl_out,
    output logic [boxov_pkg::RATIO_W-1:0] ratio
);

    localparam int VW = boxov_pkg::VOL_W;
    localparam int QB = boxov_pkg::RATIO_FRAC_BITS;

    // saturation check and divider setup
    boxov_pkg::ctl_t ctl_s_reg;
    logic            sat_s_reg;
    logic [VW-1:0]   rem_s_reg;
    logic [VW-1:0]   den_s_reg;

    // one quotient bit per stage
    boxov_pkg::ctl_t ctl_q_reg [QB];
    logic            sat_q_reg [QB];
    logic [VW-1:0]   rem_q_reg [QB];
    logic [VW-1:0]   den_q_reg [QB];
    logic [QB-1:0]   quo_q_reg [QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s_reg <= '0;
        end
        else if (en)
        begin
            ctl_s_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_s_reg <= (num >= den);
            rem_s_reg <= num;
            den_s_reg <= den;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        boxov_pkg::ctl_t ctl_prev;
        logic            sat_prev;
        logic [VW-1:0]   rem_prev;
        logic [VW-1:0]   den_prev;
        logic [QB-1:0]   quo_prev;
        logic [VW:0]     shifted;
        logic [VW:0]     diff;
        logic            take;
        logic [VW-1:0]   rem_next;
        logic [QB-1:0]   quo_next;

        if (k == 0)
        begin : g_first
            assign ctl_prev = ctl_s_reg;
            assign sat_prev = sat_s_reg;
            assign rem_prev = rem_s_reg;
            assign den_prev = den_s_reg;
            assign quo_prev = '0;
        end
        else
        begin : g_rest
            assign ctl_prev = ctl_q_reg[k-1];
            assign sat_prev = sat_q_reg[k-1];
            assign rem_prev = rem_q_reg[k-1];
            assign den_prev = den_q_reg[k-1];
            assign quo_prev = quo_q_reg[k-1];
        end

        always_comb
        begin
            shifted  = {rem_prev, 1'b0};
            diff     = shifted - {1'b0, den_prev};
            take     = !diff[VW];
            rem_next = take ? diff[VW-1:0] : shifted[VW-1:0];
            quo_next = {quo_prev[QB-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_q_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_q_reg[k] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_q_reg[k] <= sat_prev;
                rem_q_reg[k] <= rem_next;
                den_q_reg[k] <= den_prev;
                quo_q_reg[k] <= quo_next;
            end
        end
    end

    always_comb
    begin
        ctl_out = ctl_q_reg[QB-1];
        priority if (ctl_q_reg[QB-1].zero || (ctl_q_reg[QB-1].status != boxov_pkg::ST_OK))
        begin
            ratio = '0;
        end
        else if (sat_q_reg[QB-1])
        begin
            ratio = boxov_pkg::RATIO_ONE;
        end
        else
        begin
            ratio = {1'b0, quo_q_reg[QB-1]};
        end
    end

endmodule

### design/boxov_outbuf.sv
module boxov_outbuf (
    input  logic                           clk,
    input  logic                           rst_n,
    input  boxov_pkg::ctl_t                ctl_in,
    input  logic [boxov_pkg::RATIO_W-1:0]  ratio_in,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [boxov_pkg::RATIO_W-1:0]  out_ratio,
    output logic [boxov_pkg::STATUS_W-1:0] out_status,
    output logic                           en
);

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [boxov_pkg::RATIO_W-1:0]  out_ratio_reg;
    logic [boxov_pkg::RATIO_W-1:0]  out_ratio_next;
    logic [boxov_pkg::STATUS_W-1:0] out_status_reg;
    logic [boxov_pkg::STATUS_W-1:0] out_status_next;
    logic                           skid_valid_reg;
    logic                           skid_valid_next;
    logic [boxov_pkg::RATIO_W-1:0]  skid_ratio_reg;
    logic [boxov_pkg::RATIO_W-1:0]  skid_ratio_next;
    logic [boxov_pkg::STATUS_W-1:0] skid_status_reg;
    logic [boxov_pkg::STATUS_W-1:0] skid_status_next;
    logic                           take;

    always_comb
    begin
        take             = out_valid_reg && out_ready;
        out_valid_next   = out_valid_reg;
        out_ratio_next   = out_ratio_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_ratio_next  = skid_ratio_reg;
        skid_status_next = skid_status_reg;
        priority if (skid_valid_reg)
        begin
            // pipeline frozen, drain skid first
            if (take)
            begin
                out_ratio_next  = skid_ratio_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (ctl_in.valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next  = 1'b1;
                out_ratio_next  = ratio_in;
                out_status_next = ctl_in.status;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_ratio_next  = ratio_in;
                skid_status_next = ctl_in.status;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ratio_reg   <= out_ratio_next;
        out_status_reg  <= out_status_next;
        skid_ratio_reg  <= skid_ratio_next;
        skid_status_reg <= skid_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_ratio  = out_ratio_reg;
    assign out_status = out_status_reg;
    assign en         = !skid_valid_reg;

endmodule

### design/box_overlap_volume_ratio_core.sv
// box overlap volume ratio core
// input stream: one item per box pair, tdata holds the twelve 24-bit signed
// corner coordinates (8 fraction bits), scan max xyz, scan min xyz, map max
// xyz, map min xyz, lowest bits first
// output stream: one item per input item, tdata holds the Q1.16 ratio of
// intersection volume over scan volume, tuser the status code
// (ok, disjoint, scan volume not positive)
// pipeline: the front stage, the three multiply stages, the saturation check,
// the 16-stage restoring divider, one quotient bit per stage, and the output
// register lie between the accepting edge and tvalid on the output
// throughput: one item per cycle, every stage advancing, while tready is high
// reset: all valid bits clear, no item is pending, tready comes up high
// stall: an output register and one skid entry sit behind the pipeline;
// when the receiver holds off and the skid fills, tready drops and the whole
// pipeline freezes until the skid drains, nothing is dropped or repeated
module box_overlap_volume_ratio_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // scan_max_x, scan_max_y, scan_max_z, scan_min_x, scan_min_y, scan_min_z,
    // map_max_x, map_max_y, map_max_z, map_min_x, map_min_y, map_min_z
    input  logic [boxov_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // overlap_ratio, zero fill
    output logic [boxov_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [boxov_pkg::STATUS_W-1:0]    m_axis_tuser
);

`include "box_overlap_volume_ratio_core_assert.svh"

    logic                             en;
    boxov_pkg::ctl_t                  front_ctl;
    logic [2:0][boxov_pkg::MAG_W-1:0] front_ext;
    logic [2:0][boxov_pkg::MAG_W-1:0] front_ov;
    boxov_pkg::ctl_t                  mult_ctl;
    logic [boxov_pkg::VOL_W-1:0]      mult_den;
    logic [boxov_pkg::VOL_W-1:0]      mult_num;
    boxov_pkg::ctl_t                  div_ctl;
    logic [boxov_pkg::RATIO_W-1:0]    div_ratio;
    logic [boxov_pkg::RATIO_W-1:0]    out_ratio;

    boxov_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .ctl      (front_ctl),
        .ext      (front_ext),
        .ov       (front_ov)
    );

    boxov_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .ext     (front_ext),
        .ov      (front_ov),
        .ctl_out (mult_ctl),
        .den     (mult_den),
        .num     (mult_num)
    );

    boxov_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (mult_ctl),
        .num     (mult_num),
        .den     (mult_den),
        .ctl_out (div_ctl),
        .ratio   (div_ratio)
    );

    boxov_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (div_ctl),
        .ratio_in   (div_ratio),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ratio  (out_ratio),
        .out_status (m_axis_tuser),
        .en         (en)
    );

    assign s_axis_tready = en;
    assign m_axis_tdata  = boxov_pkg::OUT_DATA_W'(out_ratio);

    `BOXOV_ASSERT_SAME(a_stall_needs_full_output, !s_axis_tready, m_axis_tvalid)
    `BOXOV_ASSERT_SAME(a_bad_status_zero_ratio,
        m_axis_tvalid && (m_axis_tuser != boxov_pkg::ST_OK), out_ratio == '0)
    `BOXOV_ASSERT_SAME(a_ratio_capped, m_axis_tvalid, out_ratio <= boxov_pkg::RATIO_ONE)
    `BOXOV_ASSERT_NEXT(a_stall_holds, !s_axis_tready && !m_axis_tready, !s_axis_tready)

endmodule
